### rtl/core/basic_source_lexer_macros.svh
// ----------------------------------------------------------------------------
// basic_source_lexer assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef BASIC_SOURCE_LEXER_MACROS_SVH
`define BASIC_SOURCE_LEXER_MACROS_SVH

// property must hold at every edge out of reset
`define BSL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define BSL_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### rtl/core/bsl_pkg.sv
// ----------------------------------------------------------------------------
// bsl_pkg
// Shared widths, token codes, result word types and the keyword table.
// ----------------------------------------------------------------------------
package bsl_pkg;

	localparam int KEYWORD_CHARS = 7;
	localparam int LINE_BITS     = 16;
	localparam int COLUMN_BITS   = 8;
	localparam int KW_COUNT      = 107;
	localparam int KW_TEXT_BYTES = 7;
	localparam int QUEUE_DEPTH   = 2;
	localparam int RES_MAX       = 3;

	localparam logic [3:0] TK_EOT     = 4'd0;
	localparam logic [3:0] TK_EOL     = 4'd1;
	localparam logic [3:0] TK_SYM     = 4'd2;
	localparam logic [3:0] TK_BLANK   = 4'd3;
	localparam logic [3:0] TK_STR     = 4'd4;
	localparam logic [3:0] TK_COMMENT = 4'd5;
	localparam logic [3:0] TK_IDENT   = 4'd6;
	localparam logic [3:0] TK_KEYWORD = 4'd7;
	localparam logic [3:0] TK_OP      = 4'd8;
	localparam logic [3:0] TK_NUM     = 4'd9;

	localparam logic [1:0] CL_PLAIN = 2'd0;
	localparam logic [1:0] CL_FUNC  = 2'd1;
	localparam logic [1:0] CL_OPER  = 2'd2;
	localparam logic [1:0] CL_NOT   = 2'd3;

	typedef struct packed {
		logic [3:0]  token_type;
		logic [6:0]  keyword_number;
		logic [1:0]  value_kind;
		logic        is_function_word;
		logic [7:0]  first_char;
		logic [7:0]  second_char;
		logic [15:0] line_number;
		logic [7:0]  start_column;
		logic [7:0]  token_length;
	} tok_t;

	typedef struct packed {
		logic [1:0]           n;
		tok_t [RES_MAX-1:0]   tok;
	} group_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic [KW_TEXT_BYTES*8-1:0] text;
		logic [1:0]                 cls;
	} kw_row_t;

	function automatic kw_row_t kw_row(input logic [6:0] k);
		case (k)
			7'd1:   kw_row = '{"ABS", CL_FUNC};
			7'd2:   kw_row = '{"AND", CL_OPER};
			7'd3:   kw_row = '{"ASC", CL_FUNC};
			7'd4:   kw_row = '{"AT", CL_FUNC};
			7'd5:   kw_row = '{"ATN", CL_FUNC};
			7'd6:   kw_row = '{"AUTO", CL_PLAIN};
			7'd7:   kw_row = '{"BEEP", CL_PLAIN};
			7'd8:   kw_row = '{"BLOAD", CL_PLAIN};
			7'd9:   kw_row = '{"BSAVE", CL_PLAIN};
			7'd10:  kw_row = '{"BIN$", CL_FUNC};
			7'd11:  kw_row = '{"CDBL", CL_FUNC};
			7'd12:  kw_row = '{"CHR$", CL_FUNC};
			7'd13:  kw_row = '{"CINT", CL_FUNC};
			7'd14:  kw_row = '{"CIRCLE", CL_PLAIN};
			7'd15:  kw_row = '{"CLEAR", CL_PLAIN};
			7'd16:  kw_row = '{"CLOAD", CL_PLAIN};
			7'd17:  kw_row = '{"CLS", CL_PLAIN};
			7'd18:  kw_row = '{"COLOR", CL_PLAIN};
			7'd19:  kw_row = '{"CONT", CL_PLAIN};
			7'd20:  kw_row = '{"COS", CL_FUNC};
			7'd21:  kw_row = '{"CSAVE", CL_PLAIN};
			7'd22:  kw_row = '{"CSNG", CL_FUNC};
			7'd23:  kw_row = '{"CSRLIN", CL_FUNC};
			7'd24:  kw_row = '{"CLOSE", CL_PLAIN};
			7'd25:  kw_row = '{"SCREEN", CL_PLAIN};
			7'd26:  kw_row = '{"DELETE", CL_PLAIN};
			7'd27:  kw_row = '{"DIM", CL_PLAIN};
			7'd28:  kw_row = '{"DRAW", CL_PLAIN};
			7'd29:  kw_row = '{"DATA", CL_PLAIN};
			7'd30:  kw_row = '{"DEF", CL_PLAIN};
			7'd31:  kw_row = '{"ELSE", CL_PLAIN};
			7'd32:  kw_row = '{"END", CL_PLAIN};
			7'd33:  kw_row = '{"EOF", CL_FUNC};
			7'd34:  kw_row = '{"EQV", CL_OPER};
			7'd35:  kw_row = '{"EXP", CL_FUNC};
			7'd36:  kw_row = '{"FILES", CL_PLAIN};
			7'd37:  kw_row = '{"FIX", CL_FUNC};
			7'd38:  kw_row = '{"FN", CL_FUNC};
			7'd39:  kw_row = '{"FOR", CL_PLAIN};
			7'd40:  kw_row = '{"FRE", CL_FUNC};
			7'd41:  kw_row = '{"GOSUB", CL_PLAIN};
			7'd42:  kw_row = '{"GOTO", CL_PLAIN};
			7'd43:  kw_row = '{"HEX$", CL_FUNC};
			7'd44:  kw_row = '{"IF", CL_PLAIN};
			7'd45:  kw_row = '{"IMP", CL_OPER};
			7'd46:  kw_row = '{"INKEY$", CL_FUNC};
			7'd47:  kw_row = '{"INP", CL_FUNC};
			7'd48:  kw_row = '{"INPUT", CL_PLAIN};
			7'd49:  kw_row = '{"INT", CL_FUNC};
			7'd50:  kw_row = '{"KEY", CL_PLAIN};
			7'd51:  kw_row = '{"LEN", CL_FUNC};
			7'd52:  kw_row = '{"LET", CL_PLAIN};
			7'd53:  kw_row = '{"LIST", CL_PLAIN};
			7'd54:  kw_row = '{"LLIST", CL_PLAIN};
			7'd55:  kw_row = '{"LOAD", CL_PLAIN};
			7'd56:  kw_row = '{"LOCATE", CL_PLAIN};
			7'd57:  kw_row = '{"LOG", CL_FUNC};
			7'd58:  kw_row = '{"LPOS", CL_FUNC};
			7'd59:  kw_row = '{"LPRINT", CL_PLAIN};
			7'd60:  kw_row = '{"LINE", CL_PLAIN};
			7'd61:  kw_row = '{"MID$", CL_FUNC};
			7'd62:  kw_row = '{"MOD", CL_OPER};
			7'd63:  kw_row = '{"MERGE", CL_PLAIN};
			7'd64:  kw_row = '{"NEW", CL_PLAIN};
			7'd65:  kw_row = '{"NEXT", CL_PLAIN};
			7'd66:  kw_row = '{"NOT", CL_NOT};
			7'd67:  kw_row = '{"ON", CL_PLAIN};
			7'd68:  kw_row = '{"OR", CL_OPER};
			7'd69:  kw_row = '{"OPEN", CL_PLAIN};
			7'd70:  kw_row = '{"OCT$", CL_FUNC};
			7'd71:  kw_row = '{"OUT", CL_PLAIN};
			7'd72:  kw_row = '{"OUTPUT", CL_PLAIN};
			7'd73:  kw_row = '{"PAINT", CL_PLAIN};
			7'd74:  kw_row = '{"PEEK", CL_FUNC};
			7'd75:  kw_row = '{"PI", CL_FUNC};
			7'd76:  kw_row = '{"POINT", CL_FUNC};
			7'd77:  kw_row = '{"POKE", CL_PLAIN};
			7'd78:  kw_row = '{"POS", CL_FUNC};
			7'd79:  kw_row = '{"PRESET", CL_PLAIN};
			7'd80:  kw_row = '{"PRINT", CL_PLAIN};
			7'd81:  kw_row = '{"PSET", CL_PLAIN};
			7'd82:  kw_row = '{"REM", CL_PLAIN};
			7'd83:  kw_row = '{"RENUM", CL_PLAIN};
			7'd84:  kw_row = '{"RETURN", CL_PLAIN};
			7'd85:  kw_row = '{"RND", CL_FUNC};
			7'd86:  kw_row = '{"READ", CL_PLAIN};
			7'd87:  kw_row = '{"RESTORE", CL_PLAIN};
			7'd88:  kw_row = '{"SAVE", CL_PLAIN};
			7'd89:  kw_row = '{"SGN", CL_FUNC};
			7'd90:  kw_row = '{"SIN", CL_FUNC};
			7'd91:  kw_row = '{"SQR", CL_FUNC};
			7'd92:  kw_row = '{"STEP", CL_PLAIN};
			7'd93:  kw_row = '{"STOP", CL_PLAIN};
			7'd94:  kw_row = '{"STR$", CL_FUNC};
			7'd95:  kw_row = '{"SYSTEM", CL_PLAIN};
			7'd96:  kw_row = '{"STRING$", CL_FUNC};
			7'd97:  kw_row = '{"SPC", CL_FUNC};
			7'd98:  kw_row = '{"TAB", CL_FUNC};
			7'd99:  kw_row = '{"TAN", CL_FUNC};
			7'd100: kw_row = '{"THEN", CL_PLAIN};
			7'd101: kw_row = '{"TO", CL_PLAIN};
			7'd102: kw_row = '{"TROFF", CL_PLAIN};
			7'd103: kw_row = '{"TRON", CL_PLAIN};
			7'd104: kw_row = '{"USR", CL_FUNC};
			7'd105: kw_row = '{"VAL", CL_FUNC};
			7'd106: kw_row = '{"WIDTH", CL_PLAIN};
			7'd107: kw_row = '{"XOR", CL_OPER};
			default: kw_row = '{'0, CL_PLAIN};
		endcase
	endfunction

	// parallel compare against every table row, first row wins
	function automatic logic [6:0] kw_lookup(input logic [KEYWORD_CHARS-1:0][6:0] wch,
			input logic [3:0] n);
		kw_row_t    r;
		logic [3:0] len;
		logic       same;
		logic [6:0] idx;
		int         base;
		idx = '0;
		for (int k = KW_COUNT; k >= 1; k--) begin
			r   = kw_row(7'(k));
			len = '0;
			for (int i = 0; i < KW_TEXT_BYTES; i++) begin
				if (r.text[i*8 +: 8] != 8'd0)
					len = len + 4'd1;
			end
			same = (len == n);
			for (int i = 0; i < KW_TEXT_BYTES; i++) begin
				base = (int'(len) - 1 - i) * 8;
				if ((4'(i) < len) && (wch[i] != r.text[base +: 7]))
					same = 1'b0;
			end
			if (same)
				idx = 7'(k);
		end
		return idx;
	endfunction

	function automatic logic [1:0] kw_cls(input logic [6:0] idx);
		kw_row_t r;
		r = kw_row(idx);
		return r.cls;
	endfunction

endpackage

### rtl/core/bsl_front.sv
// ----------------------------------------------------------------------------
// bsl_front
// Takes one character word a cycle unless the queue is full, tracks the
// pending token and builds the group of up to three result words it releases.
// ----------------------------------------------------------------------------
module bsl_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      char_code,
	input  logic            end_of_text,
	input  logic            data_mode,
	input  bsl_pkg::q_stat_t q_stat,
	output logic            grp_valid,
	output bsl_pkg::group_t grp
);
	import bsl_pkg::*;

	localparam int IDX_W = $clog2(KEYWORD_CHARS);
	localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
	localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

	localparam logic [7:0] CH_TAB = 8'h09, CH_LF = 8'h0A, CH_CR = 8'h0D, CH_SP = 8'h20;
	localparam logic [7:0] CH_BANG = 8'h21, CH_QUOTE = 8'h22, CH_HASH = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24, CH_PCT = 8'h25, CH_AMP = 8'h26;
	localparam logic [7:0] CH_APOS = 8'h27, CH_STAR = 8'h2A, CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C, CH_MINUS = 8'h2D, CH_DOT = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F, CH_SEMI = 8'h3B, CH_LT = 8'h3C;
	localparam logic [7:0] CH_EQ = 8'h3D, CH_GT = 8'h3E, CH_B = 8'h42, CH_E = 8'h45;
	localparam logic [7:0] CH_H = 8'h48, CH_O = 8'h4F, CH_BSLASH = 8'h5C, CH_CARET = 8'h5E;

	typedef enum logic [3:0] {
		S_IDLE, S_BLANK, S_STRING, S_COMMENT, S_WORD, S_NUMBER, S_NUM_E,
		S_AMP, S_AMP_DATA, S_RADIX, S_OPER, S_DATA
	} state_t;

	state_t                              st_q, st_n, st_e;
	logic [KEYWORD_CHARS-1:0][6:0]       wch_q, wch_n, lk_ch;
	logic [3:0]                          wcnt_q, wcnt_n, lk_n;
	logic                                dot_q, dot_n, exp_q, exp_n, dchk_q, dchk_n;
	logic [7:0]                          held_q, held_n, tcount_q, tcount_n;
	logic [COLUMN_BITS-1:0]              tstart_q, tstart_n, col_q, col_n;
	logic [LINE_BITS-1:0]                line_q, line_n;
	logic                                acr_q, acr_n, lopen_q, lopen_n;
	logic [1:0]                          hkind_q, hkind_n;
	logic                                accept, sfx, taken, digit, letter, radix_ok;
	logic [6:0]                          lk_idx;
	logic [1:0]                          lk_cls, cnt;
	logic [7:0]                          c, cu;
	tok_t [RES_MAX-1:0]                  res;

	function automatic tok_t mk(input logic [3:0] ty, input logic [6:0] kw,
			input logic [1:0] vk, input logic fn, input logic [7:0] f,
			input logic [7:0] s, input logic [COLUMN_BITS-1:0] col,
			input logic [7:0] len, input logic [LINE_BITS-1:0] ln);
		tok_t t;
		t.token_type       = ty;
		t.keyword_number   = kw;
		t.value_kind       = vk;
		t.is_function_word = fn;
		t.first_char       = f;
		t.second_char      = s;
		t.line_number      = 16'(ln);
		t.start_column     = 8'(col);
		t.token_length     = len;
		return t;
	endfunction

	function automatic tok_t flush_tok(input state_t st, input logic [7:0] h,
			input logic [COLUMN_BITS-1:0] ts, input logic [7:0] tc,
			input logic [1:0] hk, input logic [6:0] idx, input logic [1:0] cls,
			input logic [LINE_BITS-1:0] ln);
		logic [3:0] wty;
		wty = (cls == CL_OPER || cls == CL_NOT) ? TK_OP :
			((idx != 7'd0) ? TK_KEYWORD : TK_IDENT);
		case (st)
			S_BLANK:                      return mk(TK_BLANK, '0, 2'd0, 1'b0, h, '0, ts, tc, ln);
			S_STRING, S_DATA, S_AMP_DATA: return mk(TK_STR, '0, 2'd3, 1'b0, h, '0, ts, tc, ln);
			S_COMMENT:                    return mk(TK_COMMENT, '0, 2'd0, 1'b0, h, '0, ts, tc, ln);
			S_WORD:          return mk(wty, idx, 2'd1, cls == CL_FUNC, h, '0, ts, tc, ln);
			S_NUMBER, S_NUM_E:            return mk(TK_NUM, '0, hk, 1'b0, h, '0, ts, tc, ln);
			S_RADIX:                      return mk(TK_NUM, '0, 2'd2, 1'b0, h, '0, ts, tc, ln);
			S_AMP:                        return mk(TK_SYM, '0, 2'd0, 1'b0, h, '0, ts, tc, ln);
			S_OPER:                       return mk(TK_OP, '0, 2'd0, 1'b0, h, '0, ts, tc, ln);
			default:                      return '0;
		endcase
	endfunction

	assign c        = char_code;
	assign cu       = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
	assign digit    = (c >= 8'h30 && c <= 8'h39);
	assign letter   = (cu >= 8'h41 && cu <= 8'h5A);
	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		sfx   = (st_q == S_WORD) && !end_of_text &&
			(c == CH_DOLLAR || c == CH_PCT || c == CH_BANG);
		lk_ch = wch_q;
		lk_n  = wcnt_q;
		if (sfx) begin
			if (32'(wcnt_q) < KEYWORD_CHARS)
				lk_ch[wcnt_q[IDX_W-1:0]] = c[6:0];
			if (wcnt_q != 4'hF)
				lk_n = wcnt_q + 4'd1;
		end
		lk_idx = kw_lookup(lk_ch, lk_n);
		lk_cls = kw_cls(lk_idx);
	end

	always_comb begin
		case (hkind_q)
			2'd1:    radix_ok = digit || (c >= 8'h41 && c <= 8'h46);
			2'd2:    radix_ok = (c >= 8'h30 && c <= 8'h37);
			default: radix_ok = (c == 8'h30 || c == 8'h31);
		endcase
	end

	always_comb begin
		st_n = st_q; wch_n = wch_q; wcnt_n = wcnt_q; dot_n = dot_q; exp_n = exp_q;
		dchk_n = dchk_q; held_n = held_q; tstart_n = tstart_q; tcount_n = tcount_q;
		col_n = col_q; line_n = line_q; acr_n = acr_q; lopen_n = lopen_q;
		hkind_n = hkind_q;
		res = '0; cnt = 2'd0; taken = 1'b0; st_e = st_q;
		if (end_of_text) begin
			acr_n = 1'b0;
			if (st_q != S_IDLE) begin
				res[cnt] = flush_tok(st_q, held_q, tstart_q, tcount_q, hkind_q,
					lk_idx, lk_cls, line_q);
				cnt = cnt + 2'd1;
			end
			if (st_q == S_COMMENT || lopen_q) begin
				if (st_q != S_COMMENT) begin
					res[cnt] = mk(TK_EOL, '0, 2'd0, 1'b0, '0, '0,
						(col_q != COL_MAX) ? col_q + 1'b1 : col_q, '0, line_q);
					cnt = cnt + 2'd1;
				end
				if (line_q != LINE_MAX)
					line_n = line_q + 1'b1;
				col_n = '0; lopen_n = 1'b0;
			end
			st_n = S_IDLE;
			res[cnt] = mk(TK_EOT, '0, 2'd0, 1'b0, '0, '0,
				(col_n != COL_MAX) ? col_n + 1'b1 : col_n, '0, line_n);
			cnt = cnt + 2'd1;
		end else if (c == CH_LF && acr_q) begin
			acr_n = 1'b0;
		end else if (c == CH_CR || c == CH_LF) begin
			if (st_q != S_IDLE) begin
				res[cnt] = flush_tok(st_q, held_q, tstart_q, tcount_q, hkind_q,
					lk_idx, lk_cls, line_q);
				cnt = cnt + 2'd1;
			end
			if (st_q != S_COMMENT) begin
				res[cnt] = mk(TK_EOL, '0, 2'd0, 1'b0, '0, '0,
					(col_q != COL_MAX) ? col_q + 1'b1 : col_q, '0, line_q);
				cnt = cnt + 2'd1;
			end
			if (line_q != LINE_MAX)
				line_n = line_q + 1'b1;
			col_n = '0; lopen_n = 1'b0; st_n = S_IDLE;
			acr_n = (c == CH_CR);
		end else begin
			acr_n   = 1'b0;
			lopen_n = 1'b1;
			col_n   = (col_q != COL_MAX) ? col_q + 1'b1 : col_q;
			if (st_q == S_NUM_E) begin
				st_e = S_NUMBER; st_n = S_NUMBER;
			end
			if (st_q == S_NUM_E && c == CH_MINUS) begin
				taken = 1'b1;
			end else begin
				case (st_e)
					S_BLANK: taken = (c == CH_SP || c == CH_TAB);
					S_STRING: begin
						taken = 1'b1;
						if (c == CH_QUOTE) begin
							res[cnt] = mk(TK_STR, '0, 2'd3, 1'b0, held_q, '0, tstart_q,
								(tcount_q != 8'hFF) ? tcount_q + 8'd1 : tcount_q, line_q);
							cnt = cnt + 2'd1;
							st_n = S_IDLE;
						end
					end
					S_COMMENT: taken = 1'b1;
					S_DATA: taken = (c != CH_COMMA);
					S_WORD: begin
						if (letter || digit) begin
							if (digit && !dchk_q && lk_idx != 7'd0) begin
								res[cnt] = mk((lk_cls == CL_NOT) ? TK_OP : TK_KEYWORD, lk_idx,
									2'd0, lk_cls == CL_FUNC, held_q, '0, tstart_q, tcount_q,
									line_q);
								cnt = cnt + 2'd1;
								st_n = S_IDLE;
							end else begin
								if (digit)
									dchk_n = 1'b1;
								if (32'(wcnt_q) < KEYWORD_CHARS)
									wch_n[wcnt_q[IDX_W-1:0]] = cu[6:0];
								if (wcnt_q != 4'hF)
									wcnt_n = wcnt_q + 4'd1;
								taken = 1'b1;
							end
						end else if (sfx) begin
							wch_n = lk_ch; wcnt_n = lk_n; taken = 1'b1;
							res[cnt] = mk((lk_cls == CL_OPER || lk_cls == CL_NOT) ? TK_OP :
								((lk_idx != 7'd0) ? TK_KEYWORD : TK_IDENT), lk_idx,
								(c == CH_DOLLAR) ? 2'd3 : ((c == CH_PCT) ? 2'd2 : 2'd1),
								lk_cls == CL_FUNC, held_q, '0, tstart_q,
								(tcount_q != 8'hFF) ? tcount_q + 8'd1 : tcount_q, line_q);
							cnt = cnt + 2'd1;
							st_n = S_IDLE;
						end
					end
					S_NUMBER: begin
						if (digit) begin
							taken = 1'b1;
						end else if (c == CH_DOT) begin
							taken = !dot_q; dot_n = 1'b1;
						end else if (c == CH_E) begin
							taken = !exp_q; exp_n = 1'b1;
							if (!exp_q)
								st_n = S_NUM_E;
						end else if (c == CH_PCT || c == CH_BANG || c == CH_HASH) begin
							taken = 1'b1;
							res[cnt] = mk(TK_NUM, '0, (c == CH_PCT) ? 2'd2 : 2'd1, 1'b0,
								held_q, '0, tstart_q,
								(tcount_q != 8'hFF) ? tcount_q + 8'd1 : tcount_q, line_q);
							cnt = cnt + 2'd1;
							st_n = S_IDLE;
						end
					end
					S_AMP, S_AMP_DATA: begin
						if (c == CH_H || c == CH_O || c == CH_B) begin
							taken = 1'b1;
							hkind_n = (c == CH_H) ? 2'd1 : ((c == CH_O) ? 2'd2 : 2'd3);
							st_n = S_RADIX;
						end else if (st_e == S_AMP_DATA) begin
							st_n = S_DATA;
							taken = (c != CH_COMMA);
						end
					end
					S_RADIX: taken = radix_ok;
					S_OPER: begin
						if ((held_q == CH_EQ && (c == CH_GT || c == CH_LT)) ||
								(held_q == CH_LT && (c == CH_GT || c == CH_EQ)) ||
								(held_q == CH_GT && (c == CH_LT || c == CH_EQ))) begin
							taken = 1'b1;
							res[cnt] = mk(TK_OP, '0, 2'd0, 1'b0, held_q, c, tstart_q,
								(tcount_q != 8'hFF) ? tcount_q + 8'd1 : tcount_q, line_q);
							cnt = cnt + 2'd1;
							st_n = S_IDLE;
						end
					end
					default: taken = 1'b0;
				endcase
			end
			if (taken) begin
				if (tcount_q != 8'hFF)
					tcount_n = tcount_q + 8'd1;
			end else begin
				if (st_n != S_IDLE) begin
					res[cnt] = flush_tok(st_n, held_q, tstart_q, tcount_q, hkind_q,
						lk_idx, lk_cls, line_q);
					cnt = cnt + 2'd1;
				end
				st_n = S_IDLE;
				tstart_n = col_n; tcount_n = 8'd1; held_n = c;
				if (c == CH_SP || c == CH_TAB) begin
					st_n = S_BLANK;
				end else if (c == CH_QUOTE) begin
					st_n = S_STRING;
				end else if (c == CH_APOS && !data_mode) begin
					st_n = S_COMMENT;
				end else if (letter && !data_mode) begin
					held_n = cu; wch_n[0] = cu[6:0]; wcnt_n = 4'd1; dchk_n = 1'b0;
					st_n = S_WORD;
				end else if (c == CH_COMMA || c == CH_SEMI) begin
					res[cnt] = mk(TK_SYM, '0, 2'd0, 1'b0, c, '0, col_n, 8'd1, line_q);
					cnt = cnt + 2'd1;
				end else if (digit || c == CH_DOT) begin
					dot_n = (c == CH_DOT); exp_n = 1'b0; hkind_n = 2'd1; st_n = S_NUMBER;
				end else if (c == CH_AMP) begin
					st_n = data_mode ? S_AMP_DATA : S_AMP;
				end else if (c == CH_PLUS || c == CH_MINUS || c == CH_SLASH ||
						c == CH_STAR || c == CH_CARET || c == CH_BSLASH) begin
					res[cnt] = mk(TK_OP, '0, 2'd0, 1'b0, c, '0, col_n, 8'd1, line_q);
					cnt = cnt + 2'd1;
				end else if (c == CH_EQ || c == CH_LT || c == CH_GT) begin
					st_n = S_OPER;
				end else if (data_mode) begin
					st_n = S_DATA;
				end else begin
					res[cnt] = mk(TK_SYM, '0, 2'd0, 1'b0, c, '0, col_n, 8'd1, line_q);
					cnt = cnt + 2'd1;
				end
			end
		end
	end

	assign grp_valid = accept && (cnt != 2'd0);
	assign grp.n     = cnt;
	assign grp.tok   = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; wcnt_q <= '0; dot_q <= 1'b0; exp_q <= 1'b0; dchk_q <= 1'b0;
			held_q <= '0; tstart_q <= '0; tcount_q <= '0; col_q <= '0;
			line_q <= LINE_BITS'(1); acr_q <= 1'b0; lopen_q <= 1'b0; hkind_q <= '0;
		end else if (accept) begin
			st_q <= st_n; wcnt_q <= wcnt_n; dot_q <= dot_n; exp_q <= exp_n;
			dchk_q <= dchk_n; held_q <= held_n; tstart_q <= tstart_n;
			tcount_q <= tcount_n; col_q <= col_n; line_q <= line_n; acr_q <= acr_n;
			lopen_q <= lopen_n; hkind_q <= hkind_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			wch_q <= wch_n;
	end

endmodule

### rtl/core/bsl_queue.sv
// ----------------------------------------------------------------------------
// bsl_queue
// Short queue of result groups between the front and back parts.
// ----------------------------------------------------------------------------
`include "basic_source_lexer_macros.svh"

module bsl_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bsl_pkg::group_t  wdata,
	input  logic             pop,
	output bsl_pkg::group_t  head,
	output bsl_pkg::q_stat_t stat
);
	import bsl_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	group_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  count_q;

	assign head       = mem_q[rd_q];
	assign stat.full  = (count_q == CNT_FULL);
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; count_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	`BSL_NEVER(a_no_overflow, push && stat.full, "group pushed into a full queue")
	`BSL_NEVER(a_no_underflow, pop && stat.empty, "group popped from an empty queue")
	`BSL_NEVER(a_empty_group, !stat.empty && head.n == 2'd0, "queued group holds no word")
	`BSL_ASSERT(a_count_drop, pop && !push |=> count_q == $past(count_q) - 1'b1, "count slip")

endmodule

### rtl/core/bsl_back.sv
// ----------------------------------------------------------------------------
// bsl_back
// Sends the words of the head group one per handshake and marks the last.
// ----------------------------------------------------------------------------
module bsl_back (
	input  logic             clk,
	input  logic             arst_n,
	input  bsl_pkg::group_t  head,
	input  bsl_pkg::q_stat_t q_stat,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [3:0]       token_type,
	output logic [6:0]       keyword_number,
	output logic [1:0]       value_kind,
	output logic             is_function_word,
	output logic [7:0]       first_char,
	output logic [7:0]       second_char,
	output logic [15:0]      line_number,
	output logic [7:0]       start_column,
	output logic [7:0]       token_length,
	output logic             last_of_run
);
	import bsl_pkg::*;

	logic [1:0] idx_q;
	tok_t       t;

	assign t                = head.tok[idx_q];
	assign out_valid        = !q_stat.empty;
	assign last_of_run      = (idx_q == head.n - 2'd1);
	assign pop              = out_valid && out_ready && last_of_run;
	assign token_type       = t.token_type;
	assign keyword_number   = t.keyword_number;
	assign value_kind       = t.value_kind;
	assign is_function_word = t.is_function_word;
	assign first_char       = t.first_char;
	assign second_char      = t.second_char;
	assign line_number      = t.line_number;
	assign start_column     = t.start_column;
	assign token_length     = t.token_length;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= '0;
		else if (out_valid && out_ready)
			idx_q <= last_of_run ? 2'd0 : idx_q + 2'd1;
	end

endmodule

### rtl/core/basic_source_lexer.sv
// A two-group queue between the lexer front and the output back holds result groups.
// Throughput: one character per cycle while that queue has room; the output side
// sends one word per cycle while out_ready is high, so a character that releases
// two or three words holds the output for one handshake per word.
// Reset: arst_n clears control state at once: line 1, column 0, no pending token.
// ----------------------------------------------------------------------------
// basic_source_lexer
// Streaming BASIC tokenizer with one character of lookahead.
// ----------------------------------------------------------------------------
module basic_source_lexer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        end_of_text,
	input  logic        data_mode,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  token_type,
	output logic [6:0]  keyword_number,
	output logic [1:0]  value_kind,
	output logic        is_function_word,
	output logic [7:0]  first_char,
	output logic [7:0]  second_char,
	output logic [15:0] line_number,
	output logic [7:0]  start_column,
	output logic [7:0]  token_length,
	output logic        last_of_run
);
	import bsl_pkg::*;

	group_t  grp, head;
	logic    grp_valid, pop;
	q_stat_t q_stat;

	bsl_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .char_code, .end_of_text, .data_mode,
		.q_stat, .grp_valid, .grp
	);

	bsl_queue u_queue (
		.clk, .arst_n, .push(grp_valid), .wdata(grp), .pop, .head, .stat(q_stat)
	);

	bsl_back u_back (
		.clk, .arst_n, .head, .q_stat, .pop, .out_valid, .out_ready, .token_type,
		.keyword_number, .value_kind, .is_function_word, .first_char, .second_char,
		.line_number, .start_column, .token_length, .last_of_run
	);

endmodule

### tb/basic_source_lexer_tb.sv
// ----------------------------------------------------------------------------
// basic_source_lexer_tb
// Feeds the lexer a stream of BASIC source bytes, line ends, end-of-text marks
// and DATA-mode runs under random idling on both sides. A predictor tracks the
// lexer state and queues the token words that each accepted byte should
// release; the monitor checks every output word field by field, in order.
// ----------------------------------------------------------------------------
module basic_source_lexer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bsl_pkg::*;

	localparam int LIMIT_CYCLES = 200000;

	localparam logic [1:0] VK_NONE   = 2'd0;
	localparam logic [1:0] VK_SINGLE = 2'd1;
	localparam logic [1:0] VK_INT    = 2'd2;
	localparam logic [1:0] VK_STR    = 2'd3;

	localparam logic [1:0] RX_HEX = 2'd1;
	localparam logic [1:0] RX_OCT = 2'd2;
	localparam logic [1:0] RX_BIN = 2'd3;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	typedef enum logic [3:0] {
		LX_IDLE, LX_BLANK, LX_STRING, LX_COMMENT, LX_WORD, LX_NUMBER, LX_NUM_E,
		LX_AMP, LX_AMP_DATA, LX_RADIX, LX_OPER, LX_DATA
	} lex_state_e;

	typedef struct {
		string      text;
		logic [1:0] cls;
	} kw_ent_t;

	typedef struct packed {
		logic [7:0] c;
		logic       eot;
		logic       dm;
	} src_char_t;

	typedef struct packed {
		tok_t t;
		logic last;
	} tok_due_t;

	kw_ent_t kw_tab [107] = '{
		'{"ABS",CL_FUNC}, '{"AND",CL_OPER}, '{"ASC",CL_FUNC}, '{"AT",CL_FUNC},
		'{"ATN",CL_FUNC}, '{"AUTO",CL_PLAIN}, '{"BEEP",CL_PLAIN}, '{"BLOAD",CL_PLAIN},
		'{"BSAVE",CL_PLAIN}, '{"BIN$",CL_FUNC}, '{"CDBL",CL_FUNC}, '{"CHR$",CL_FUNC},
		'{"CINT",CL_FUNC}, '{"CIRCLE",CL_PLAIN}, '{"CLEAR",CL_PLAIN}, '{"CLOAD",CL_PLAIN},
		'{"CLS",CL_PLAIN}, '{"COLOR",CL_PLAIN}, '{"CONT",CL_PLAIN}, '{"COS",CL_FUNC},
		'{"CSAVE",CL_PLAIN}, '{"CSNG",CL_FUNC}, '{"CSRLIN",CL_FUNC}, '{"CLOSE",CL_PLAIN},
		'{"SCREEN",CL_PLAIN}, '{"DELETE",CL_PLAIN}, '{"DIM",CL_PLAIN}, '{"DRAW",CL_PLAIN},
		'{"DATA",CL_PLAIN}, '{"DEF",CL_PLAIN}, '{"ELSE",CL_PLAIN}, '{"END",CL_PLAIN},
		'{"EOF",CL_FUNC}, '{"EQV",CL_OPER}, '{"EXP",CL_FUNC}, '{"FILES",CL_PLAIN},
		'{"FIX",CL_FUNC}, '{"FN",CL_FUNC}, '{"FOR",CL_PLAIN}, '{"FRE",CL_FUNC},
		'{"GOSUB",CL_PLAIN}, '{"GOTO",CL_PLAIN}, '{"HEX$",CL_FUNC}, '{"IF",CL_PLAIN},
		'{"IMP",CL_OPER}, '{"INKEY$",CL_FUNC}, '{"INP",CL_FUNC}, '{"INPUT",CL_PLAIN},
		'{"INT",CL_FUNC}, '{"KEY",CL_PLAIN}, '{"LEN",CL_FUNC}, '{"LET",CL_PLAIN},
		'{"LIST",CL_PLAIN}, '{"LLIST",CL_PLAIN}, '{"LOAD",CL_PLAIN}, '{"LOCATE",CL_PLAIN},
		'{"LOG",CL_FUNC}, '{"LPOS",CL_FUNC}, '{"LPRINT",CL_PLAIN}, '{"LINE",CL_PLAIN},
		'{"MID$",CL_FUNC}, '{"MOD",CL_OPER}, '{"MERGE",CL_PLAIN}, '{"NEW",CL_PLAIN},
		'{"NEXT",CL_PLAIN}, '{"NOT",CL_NOT}, '{"ON",CL_PLAIN}, '{"OR",CL_OPER},
		'{"OPEN",CL_PLAIN}, '{"OCT$",CL_FUNC}, '{"OUT",CL_PLAIN}, '{"OUTPUT",CL_PLAIN},
		'{"PAINT",CL_PLAIN}, '{"PEEK",CL_FUNC}, '{"PI",CL_FUNC}, '{"POINT",CL_FUNC},
		'{"POKE",CL_PLAIN}, '{"POS",CL_FUNC}, '{"PRESET",CL_PLAIN}, '{"PRINT",CL_PLAIN},
		'{"PSET",CL_PLAIN}, '{"REM",CL_PLAIN}, '{"RENUM",CL_PLAIN}, '{"RETURN",CL_PLAIN},
		'{"RND",CL_FUNC}, '{"READ",CL_PLAIN}, '{"RESTORE",CL_PLAIN}, '{"SAVE",CL_PLAIN},
		'{"SGN",CL_FUNC}, '{"SIN",CL_FUNC}, '{"SQR",CL_FUNC}, '{"STEP",CL_PLAIN},
		'{"STOP",CL_PLAIN}, '{"STR$",CL_FUNC}, '{"SYSTEM",CL_PLAIN}, '{"STRING$",CL_FUNC},
		'{"SPC",CL_FUNC}, '{"TAB",CL_FUNC}, '{"TAN",CL_FUNC}, '{"THEN",CL_PLAIN},
		'{"TO",CL_PLAIN}, '{"TROFF",CL_PLAIN}, '{"TRON",CL_PLAIN}, '{"USR",CL_FUNC},
		'{"VAL",CL_FUNC}, '{"WIDTH",CL_PLAIN}, '{"XOR",CL_OPER}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  char_code = '0;
	logic        end_of_text = 1'b0;
	logic        data_mode = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  token_type;
	logic [6:0]  keyword_number;
	logic [1:0]  value_kind;
	logic        is_function_word;
	logic [7:0]  first_char;
	logic [7:0]  second_char;
	logic [15:0] line_number;
	logic [7:0]  start_column;
	logic [7:0]  token_length;
	logic        last_of_run;

	src_char_t src_q [$];
	tok_due_t  tokens_due [$];
	tok_due_t  step_q [$];
	int        mismatches = 0;
	int        cyc = 0;
	int        hold_left = 0;

	// lexer shadow state
	lex_state_e  lx;
	logic [6:0]  wbuf [7];
	int          wcnt;
	bit          dot, expo, dchk, after_cr, line_open;
	logic [7:0]  hchar, tstart, tcount, col;
	logic [15:0] line;
	logic [1:0]  hkind;

	basic_source_lexer DUT (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic bit is_num(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [7:0] upcase(logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	function automatic void lex_reset();
		lx = LX_IDLE;
		foreach (wbuf[i]) wbuf[i] = '0;
		wcnt = 0; dot = 0; expo = 0; dchk = 0;
		hchar = '0; tstart = '0; tcount = '0; col = '0;
		line = 16'd1; after_cr = 0; line_open = 0; hkind = '0;
	endfunction

	function automatic void emit(logic [3:0] tt, logic [6:0] kw, logic [1:0] vk, logic fn,
			logic [7:0] f, logic [7:0] s, logic [7:0] cl, logic [7:0] ln);
		tok_due_t d;
		d.t.token_type = tt; d.t.keyword_number = kw; d.t.value_kind = vk;
		d.t.is_function_word = fn; d.t.first_char = f; d.t.second_char = s;
		d.t.line_number = line; d.t.start_column = cl; d.t.token_length = ln;
		d.last = 1'b0;
		step_q.push_back(d);
	endfunction

	function automatic void grow();
		if (tcount < 8'd255) tcount++;
	endfunction

	function automatic logic [7:0] next_col();
		return (col < 8'd255) ? col + 8'd1 : 8'd255;
	endfunction

	function automatic void store_word(logic [7:0] c);
		if (wcnt < KEYWORD_CHARS) wbuf[wcnt] = c[6:0];
		if (wcnt < 15) wcnt++;
	endfunction

	function automatic logic [6:0] kw_find();
		string t;
		bit    same;
		for (int k = 0; k < 107; k++) begin
			t = kw_tab[k].text;
			if (t.len() == wcnt) begin
				same = 1;
				for (int i = 0; i < t.len(); i++)
					if (wbuf[i] != 7'(t[i])) same = 0;
				if (same) return 7'(k + 1);
			end
		end
		return '0;
	endfunction

	function automatic logic [1:0] cls_of(logic [6:0] idx);
		return (idx == 0) ? CL_PLAIN : kw_tab[idx - 1].cls;
	endfunction

	function automatic void finish_word(logic [1:0] vk);
		logic [6:0] idx;
		logic [1:0] cl;
		logic [3:0] tt;
		idx = kw_find();
		cl = cls_of(idx);
		tt = (cl == CL_OPER || cl == CL_NOT) ? TK_OP : (idx != 0 ? TK_KEYWORD : TK_IDENT);
		emit(tt, idx, vk, cl == CL_FUNC, hchar, 0, tstart, tcount);
		lx = LX_IDLE;
	endfunction

	function automatic void flush();
		case (lx)
			LX_BLANK: emit(TK_BLANK, 0, VK_NONE, 0, hchar, 0, tstart, tcount);
			LX_STRING, LX_DATA, LX_AMP_DATA: emit(TK_STR, 0, VK_STR, 0, hchar, 0, tstart, tcount);
			LX_COMMENT: emit(TK_COMMENT, 0, VK_NONE, 0, hchar, 0, tstart, tcount);
			LX_WORD: finish_word(VK_SINGLE);
			LX_NUMBER, LX_NUM_E: emit(TK_NUM, 0, hkind, 0, hchar, 0, tstart, tcount);
			LX_RADIX: emit(TK_NUM, 0, VK_INT, 0, hchar, 0, tstart, tcount);
			LX_AMP: emit(TK_SYM, 0, VK_NONE, 0, hchar, 0, tstart, tcount);
			LX_OPER: emit(TK_OP, 0, VK_NONE, 0, hchar, 0, tstart, tcount);
			default: ;
		endcase
		lx = LX_IDLE;
	endfunction

	function automatic bit absorb(logic [7:0] c);
		logic [6:0] idx;
		logic [1:0] cl;
		bit         ok;
		if (lx == LX_NUM_E) begin
			if (c == "-") begin
				grow(); lx = LX_NUMBER; return 1;
			end
			lx = LX_NUMBER;
		end
		case (lx)
			LX_BLANK: if (c == " " || c == CH_TAB) begin
				grow(); return 1;
			end
			LX_STRING: begin
				grow();
				if (c == CH_QUOTE) begin
					emit(TK_STR, 0, VK_STR, 0, hchar, 0, tstart, tcount);
					lx = LX_IDLE;
				end
				return 1;
			end
			LX_COMMENT: begin
				grow(); return 1;
			end
			LX_DATA: if (c != ",") begin
				grow(); return 1;
			end
			LX_WORD: begin
				if (is_alpha(c) || is_num(c)) begin
					if (is_num(c) && !dchk) begin
						idx = kw_find();
						if (idx != 0) begin
							cl = cls_of(idx);
							emit(cl == CL_NOT ? TK_OP : TK_KEYWORD, idx, VK_NONE, cl == CL_FUNC,
								hchar, 0, tstart, tcount);
							lx = LX_IDLE;
							return 0;
						end
						dchk = 1;
					end
					store_word(upcase(c)); grow(); return 1;
				end
				if (c == "$" || c == "%" || c == "!") begin
					store_word(c); grow();
					finish_word(c == "$" ? VK_STR : (c == "%" ? VK_INT : VK_SINGLE));
					return 1;
				end
			end
			LX_NUMBER: begin
				if (is_num(c)) begin
					grow(); return 1;
				end
				if (c == ".") begin
					if (dot) return 0;
					dot = 1; grow(); return 1;
				end
				if (c == "E") begin
					if (expo) return 0;
					expo = 1; grow(); lx = LX_NUM_E; return 1;
				end
				if (c == "%" || c == "!" || c == "#") begin
					grow();
					emit(TK_NUM, 0, c == "%" ? VK_INT : VK_SINGLE, 0, hchar, 0, tstart, tcount);
					lx = LX_IDLE;
					return 1;
				end
			end
			LX_AMP, LX_AMP_DATA: begin
				if (c == "H" || c == "O" || c == "B") begin
					grow();
					hkind = (c == "H") ? RX_HEX : (c == "O" ? RX_OCT : RX_BIN);
					lx = LX_RADIX; return 1;
				end
				if (lx == LX_AMP_DATA) begin
					lx = LX_DATA;
					if (c != ",") begin
						grow(); return 1;
					end
				end
			end
			LX_RADIX: begin
				if (hkind == RX_HEX) ok = is_num(c) || (c >= "A" && c <= "F");
				else if (hkind == RX_OCT) ok = c >= "0" && c <= "7";
				else ok = c == "0" || c == "1";
				if (ok) begin
					grow(); return 1;
				end
			end
			LX_OPER: begin
				ok = (hchar == "=" && (c == ">" || c == "<")) ||
					(hchar == "<" && (c == ">" || c == "=")) ||
					(hchar == ">" && (c == "<" || c == "="));
				if (ok) begin
					grow();
					emit(TK_OP, 0, VK_NONE, 0, hchar, c, tstart, tcount);
					lx = LX_IDLE;
					return 1;
				end
			end
			default: ;
		endcase
		return 0;
	endfunction

	function automatic void begin_token(logic [7:0] c, bit dm);
		tstart = col; tcount = 8'd1; hchar = c;
		if (c == " " || c == CH_TAB) lx = LX_BLANK;
		else if (c == CH_QUOTE) lx = LX_STRING;
		else if (c == CH_APOS && !dm) lx = LX_COMMENT;
		else if (is_alpha(c) && !dm) begin
			hchar = upcase(c); wcnt = 0; store_word(hchar); dchk = 0; lx = LX_WORD;
		end
		else if (c == "," || c == ";") emit(TK_SYM, 0, VK_NONE, 0, c, 0, tstart, 1);
		else if (is_num(c) || c == ".") begin
			dot = (c == "."); expo = 0; hkind = VK_SINGLE; lx = LX_NUMBER;
		end
		else if (c == "&") lx = dm ? LX_AMP_DATA : LX_AMP;
		else if (c == "+" || c == "-" || c == "/" || c == "*" || c == "^" || c == CH_BSL)
			emit(TK_OP, 0, VK_NONE, 0, c, 0, tstart, 1);
		else if (c == "=" || c == "<" || c == ">") lx = LX_OPER;
		else if (dm) lx = LX_DATA;
		else emit(TK_SYM, 0, VK_NONE, 0, c, 0, tstart, 1);
	endfunction

	function automatic void new_line();
		if (line != 16'hFFFF) line++;
		col = '0; line_open = 0; lx = LX_IDLE;
	endfunction

	function automatic void lex_char(src_char_t s);
		step_q.delete();
		if (s.eot) begin
			after_cr = 0;
			if (lx == LX_COMMENT) begin
				flush(); new_line();
			end else begin
				flush();
				if (line_open) begin
					emit(TK_EOL, 0, VK_NONE, 0, 0, 0, next_col(), 0);
					new_line();
				end
			end
			emit(TK_EOT, 0, VK_NONE, 0, 0, 0, next_col(), 0);
		end else if (s.c == CH_LF && after_cr) begin
			after_cr = 0;
		end else if (s.c == CH_CR || s.c == CH_LF) begin
			if (lx == LX_COMMENT) flush();
			else begin
				flush();
				emit(TK_EOL, 0, VK_NONE, 0, 0, 0, next_col(), 0);
			end
			new_line();
			after_cr = (s.c == CH_CR);
		end else begin
			after_cr = 0;
			line_open = 1;
			col = next_col();
			if (!absorb(s.c)) begin
				flush();
				begin_token(s.c, s.dm);
			end
		end
		if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
		foreach (step_q[i]) tokens_due.push_back(step_q[i]);
	endfunction

	task automatic report(string what, logic [15:0] got, logic [15:0] want);
		$display("%0t ns mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// stimulus helpers
	task automatic push_char(logic [7:0] c, bit dm);
		src_q.push_back('{c: c, eot: 1'b0, dm: dm});
	endtask

	task automatic push_text(string s, bit dm);
		for (int i = 0; i < s.len(); i++) push_char(s[i], dm);
	endtask

	function automatic logic [7:0] pick(string s);
		return s[$urandom_range(s.len() - 1)];
	endfunction

	function automatic logic [7:0] mixcase(logic [7:0] c);
		return (is_alpha(c) && $urandom_range(1)) ? (c | 8'h20) : c;
	endfunction

	task automatic push_fragment(bit dm);
		string t;
		int    n;
		case ($urandom_range(15))
			0, 1, 2: begin
				t = kw_tab[$urandom_range(106)].text;
				for (int i = 0; i < t.len(); i++) push_char(mixcase(t[i]), dm);
				case ($urandom_range(3))
					0: push_text("70", dm);
					1: push_char(pick("$%!"), dm);
					default: push_char(" ", dm);
				endcase
			end
			3: begin
				t = $urandom_range(1) ? "NOT" : ($urandom_range(1) ? "MOD" : "XOR");
				push_text(t, dm);
				push_char($urandom_range(1) ? "5" : " ", dm);
			end
			4: begin
				push_char(mixcase(pick("ABCXYZQ")), dm);
				n = $urandom_range(10);
				repeat (n) push_char(mixcase(pick("ABCDEFXY0123456789")), dm);
				if ($urandom_range(1)) push_char(pick("$%!"), dm);
			end
			5: begin
				push_char(pick("0123456789."), dm);
				repeat ($urandom_range(4)) push_char(pick("0123456789.E-e"), dm);
				if ($urandom_range(1)) push_char(pick("%!#"), dm);
			end
			6: begin
				push_char("&", dm);
				push_char(pick("HOBhXob,"), dm);
				repeat ($urandom_range(5)) push_char(pick("0123456789ABCDEFGa"), dm);
			end
			7: begin
				push_char(CH_QUOTE, dm);
				repeat ($urandom_range(6)) push_char(pick("AB 1,'x&"), dm);
				if ($urandom_range(3) != 0) push_char(CH_QUOTE, dm);
			end
			8: begin
				push_char(CH_APOS, dm);
				repeat ($urandom_range(6)) push_char(pick("ab ,9\""), dm);
			end
			9: begin
				push_char(pick("+-*/^=<>"), dm);
				push_char(pick("=<>+ 1"), dm);
			end
			10: repeat ($urandom_range(1, 3)) push_char(pick(" \t"), dm);
			11: push_char(pick(",;:"), dm);
			12: case ($urandom_range(2))
				0: push_char(CH_CR, dm);
				1: push_char(CH_LF, dm);
				default: begin
					push_char(CH_CR, dm); push_char(CH_LF, dm);
				end
			endcase
			13: repeat ($urandom_range(1, 3)) push_char(8'($urandom_range(255)), dm);
			14: if ($urandom_range(2) == 0) src_q.push_back('{c: 8'($urandom_range(255)),
				eot: 1'b1, dm: dm});
			default: begin
				push_text("A=", dm);
				push_char(pick("0123456789"), dm);
				push_char(CH_CR, dm);
			end
		endcase
	endtask

	task automatic build_stimulus();
		bit dm;
		int base;
		// directed opening
		push_text("IF a<=.5E-3THEN7", 0);
		push_char(CH_CR, 0); push_char(CH_LF, 0);
		push_char(8'h00, 0); push_char(8'hFF, 0);
		push_text("&Z,", 1);
		src_q.push_back('{c: 8'hFF, eot: 1'b1, dm: 1'b1});
		base = src_q.size();
		dm = 0;
		while (src_q.size() - base < 280) begin
			if ($urandom_range(9) == 0) dm = ~dm;
			push_fragment(dm);
		end
		src_q.push_back('{c: 8'h00, eot: 1'b1, dm: 1'b0});
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		src_char_t s;
		bit        quiet;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			quiet = (cyc >= 900 && cyc < 1300);
			if (in_valid && in_ready)
				lex_char('{c: char_code, eot: end_of_text, dm: data_mode});
			if (!(in_valid && !in_ready)) begin
				if (src_q.size() > 0 && (quiet || $urandom_range(99) >= 31)) begin
					s = src_q.pop_front();
					in_valid <= 1'b1;
					char_code <= s.c;
					end_of_text <= s.eot;
					data_mode <= s.dm;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (cyc == 300) hold_left <= 80;
		else if (hold_left != 0) hold_left <= hold_left - 1;
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		tok_due_t want;
		bit       quiet;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			quiet = (cyc >= 900 && cyc < 1300);
			if (out_valid && out_ready) begin
				if (tokens_due.size() == 0) begin
					report("unexpected word type", 16'(token_type), 16'h0);
				end else begin
					want = tokens_due.pop_front();
					if (token_type !== want.t.token_type)
						report("token_type", 16'(token_type), 16'(want.t.token_type));
					if (keyword_number !== want.t.keyword_number)
						report("keyword_number", 16'(keyword_number), 16'(want.t.keyword_number));
					if (value_kind !== want.t.value_kind)
						report("value_kind", 16'(value_kind), 16'(want.t.value_kind));
					if (is_function_word !== want.t.is_function_word)
						report("is_function_word", 16'(is_function_word),
							16'(want.t.is_function_word));
					if (first_char !== want.t.first_char)
						report("first_char", 16'(first_char), 16'(want.t.first_char));
					if (second_char !== want.t.second_char)
						report("second_char", 16'(second_char), 16'(want.t.second_char));
					if (line_number !== want.t.line_number)
						report("line_number", line_number, want.t.line_number);
					if (start_column !== want.t.start_column)
						report("start_column", 16'(start_column), 16'(want.t.start_column));
					if (token_length !== want.t.token_length)
						report("token_length", 16'(token_length), 16'(want.t.token_length));
					if (last_of_run !== want.last)
						report("last_of_run", 16'(last_of_run), 16'(want.last));
				end
			end
			out_ready <= (hold_left == 0) && (quiet || $urandom_range(99) >= 31);
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= LIMIT_CYCLES) begin
			$display("basic_source_lexer_tb: done, errors");
			$finish;
		end
	end

	initial begin
		lex_reset();
		build_stimulus();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (src_q.size() > 0 || in_valid || tokens_due.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && tokens_due.size() == 0) begin
			$display("basic_source_lexer_tb: done, clean");
		end else begin
			$display("basic_source_lexer_tb: done, errors");
		end
		$finish;
	end

endmodule
